FILE: src/bvsg_pkg.sv
// Shared constants, types and helpers for the Brownian vertex step block.
`default_nettype none

package bvsg_pkg;

    localparam int VERTEX_INDEX_BITS_DEF = 16;

    // splitmix64 constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_M1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_M2     = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] KEY_XOR    = 64'hD1B5_4A32_D192_ED03;

    // 2*ln2 in Q22
    localparam logic [22:0] TWO_LN2_Q22 = 23'd5814540;

    // cos(pi*g/2) polynomial, Q30
    localparam logic [30:0] COS_C1 = 31'd1324675879;
    localparam logic [30:0] COS_C2 = 31'd272375560;
    localparam logic [30:0] COS_C3 = 31'd22401992;
    localparam logic [30:0] COS_C4 = 31'd987048;
    localparam logic [30:0] COS_C5 = 31'd27060;

    // pipeline depths
    localparam int MIX_LAT    = 5;
    localparam int COS_LAT    = 6;
    localparam int LOG_STEPS  = 30;
    localparam int SQRT_STEPS = 27;

    localparam int OUT_TDATA_W = 56;

    // config register indexes
    localparam logic [1:0] CFG_SEED        = 2'd0;
    localparam logic [1:0] CFG_STEP_INDEX  = 2'd1;
    localparam logic [1:0] CFG_FORCE_SCALE = 2'd2;
    localparam logic [1:0] CFG_NOISE_SCALE = 2'd3;

    // per-item fields that ride alongside the noise draw
    typedef struct packed {
        logic               frozen;
        logic signed [32:0] fsum;
        logic signed [31:0] z;
    } side_t;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

endpackage

`default_nettype wire

FILE: src/bvsg_delay.sv
// Enable-gated shift register delay line.
`default_nettype none

module bvsg_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d_in,
    output logic      [WIDTH-1:0] d_out
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d_in;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign d_out = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: src/bvsg_mix64.sv
// Pipelined splitmix64 finalizer, 64-bit products split into 32-bit parts.
`default_nettype none

module bvsg_mix64
    import bvsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] x_in,
    output logic      [63:0] x_out
);

    logic [63:0] a_reg, b_ll_reg, c_reg, d_ll_reg, e_reg;
    logic [31:0] b_hl_reg, b_lh_reg, d_hl_reg, d_lh_reg;
    logic [63:0] b_sh, d_sh;

    assign b_sh = a_reg ^ (a_reg >> 30);
    assign d_sh = c_reg ^ (c_reg >> 27);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= x_in + MIX_GOLDEN;
            b_ll_reg <= mul32(b_sh[31:0], MIX_M1[31:0]);
            b_hl_reg <= 32'(mul32(b_sh[63:32], MIX_M1[31:0]));
            b_lh_reg <= 32'(mul32(b_sh[31:0], MIX_M1[63:32]));
            c_reg    <= b_ll_reg + {b_hl_reg + b_lh_reg, 32'd0};
            d_ll_reg <= mul32(d_sh[31:0], MIX_M2[31:0]);
            d_hl_reg <= 32'(mul32(d_sh[63:32], MIX_M2[31:0]));
            d_lh_reg <= 32'(mul32(d_sh[31:0], MIX_M2[63:32]));
            e_reg    <= d_ll_reg + {d_hl_reg + d_lh_reg, 32'd0};
        end
    end

    assign x_out = e_reg ^ (e_reg >> 31);

endmodule

`default_nettype wire

FILE: src/bvsg_cos.sv
// Pipelined cosine of a 32-bit phase, Q30 signed result.
`default_nettype none

module bvsg_cos
    import bvsg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic        [31:0] phase,
    output logic signed      [31:0] cos_q30
);

    logic [1:0]  q_reg [5];
    logic [30:0] y_reg [5];
    logic [30:0] hp_reg [1:4];
    logic signed [31:0] c_reg;

    logic [29:0] f;
    logic [30:0] g;
    logic [31:0] c_val;

    function automatic logic [30:0] prodsh(input logic [30:0] a, input logic [30:0] b);
        logic [63:0] pr;
        pr = mul32(32'(a), 32'(b));
        return pr[60:30];
    endfunction

    assign f = phase[29:0];
    assign g = phase[30] ? (31'h4000_0000 - 31'(f)) : 31'(f);
    assign c_val = 32'h4000_0000 - 32'(prodsh(hp_reg[4], y_reg[4]));

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]  <= phase[31:30];
            y_reg[0]  <= prodsh(g, g);
            for (int i = 1; i < 5; i++) begin
                q_reg[i] <= q_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
            hp_reg[1] <= COS_C4 - prodsh(COS_C5, y_reg[0]);
            hp_reg[2] <= COS_C3 - prodsh(hp_reg[1], y_reg[1]);
            hp_reg[3] <= COS_C2 - prodsh(hp_reg[2], y_reg[2]);
            hp_reg[4] <= COS_C1 - prodsh(hp_reg[3], y_reg[3]);
            // second and third quadrants are negative
            c_reg     <= (q_reg[4][0] ^ q_reg[4][1]) ? -signed'(c_val) : signed'(c_val);
        end
    end

    assign cos_q30 = c_reg;

endmodule

`default_nettype wire

FILE: src/brownian_vertex_step_with_keyed_gaussian_unit.sv
// Top level: Brownian height update with a keyed Gaussian noise draw.
//
// Usage:
//   s_ channel: one vertex per beat. s_tdata holds, from bit 0 up,
//   vertex_index, curvature_force, area_force, position_z; s_tuser holds
//   force_invalid (bit 0) and frozen (bit 1).
//   m_ channel: one result beat per input beat, in order. m_tdata holds
//   new_position_z (bits 31:0) and noise_sample (bits 51:32).
//   cfg_we / cfg_index / cfg_wdata write seed, step_index, force_scale,
//   noise_scale; write only while no beat is in flight.
// Pipeline: three chained splitmix64 hashes, the 30-step log2 squaring
//   chain and the 27-step square root, plus the output math.
// Throughput: one beat per cycle. Every stage has a valid bit; the whole
//   pipe advances whenever the output register is empty or being taken.
// Reset (aresetn low, synchronous): valid bits and config registers cleared;
//   datapath registers are not reset, their contents are ignored until valid.
// Stall: with m_tready low and a result waiting, s_tready drops and every
//   stage holds its contents; nothing is dropped or repeated.
`default_nettype none

module brownian_vertex_step_with_keyed_gaussian_unit
    import bvsg_pkg::*;
#(
    parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    // vertex_index, curvature_force, area_force, position_z, zero pad
    input  wire logic [((VERTEX_INDEX_BITS+96+7)/8)*8-1:0]     s_tdata,
    // force_invalid, frozen
    input  wire logic [1:0]                                    s_tuser,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    // new_position_z, noise_sample, zero pad
    output logic [OUT_TDATA_W-1:0]                             m_tdata,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    input  wire logic                                          cfg_we,
    input  wire logic [1:0]                                    cfg_index,
    input  wire logic [63:0]                                   cfg_wdata
);

    localparam int VB = VERTEX_INDEX_BITS;
    // cycle at which hash words are ready, sqrt is done, total latency
    localparam int L_HASH = 3*MIX_LAT + 1;
    localparam int L_ROOT = L_HASH + 2 + LOG_STEPS + 1 + SQRT_STEPS;
    localparam int LAT    = L_ROOT + 5;
    localparam int COS_DLY  = L_ROOT - L_HASH - COS_LAT;
    localparam int SIDE_DLY = L_ROOT + 2;

    // ---------------- configuration ----------------
    logic [63:0] seed_reg;
    logic [31:0] step_reg, fscale_reg, nscale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            step_reg   <= '0;
            fscale_reg <= '0;
            nscale_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SEED:        seed_reg   <= cfg_wdata;
                CFG_STEP_INDEX:  step_reg   <= cfg_wdata[31:0];
                CFG_FORCE_SCALE: fscale_reg <= cfg_wdata[31:0];
                CFG_NOISE_SCALE: nscale_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- input unpack ----------------
    logic [VB-1:0]      in_idx;
    logic signed [31:0] in_fc, in_fa, in_z;
    side_t              side_in, side_out;
    logic [63:0]        idx_key;

    assign in_idx  = s_tdata[VB-1:0];
    assign in_fc   = s_tdata[VB+31:VB];
    assign in_fa   = s_tdata[VB+63:VB+32];
    assign in_z    = s_tdata[VB+95:VB+64];
    assign idx_key = {62'(in_idx), 2'b10};

    always_comb begin
        side_in.frozen = s_tuser[1];
        side_in.fsum   = s_tuser[0] ? 33'sd0 : (33'(in_fc) + 33'(in_fa));
        side_in.z      = in_z;
    end

    bvsg_delay #(.WIDTH($bits(side_t)), .DEPTH(SIDE_DLY)) u_side_dly (
        .aclk(aclk), .en(en), .d_in(side_in), .d_out(side_out)
    );

    // ---------------- key derivation ----------------
    logic [63:0] hash_seed, hash_idx, key, b1, b2;
    logic [63:0] ks_reg;

    bvsg_mix64 u_mix_seed (.aclk(aclk), .en(en), .x_in(seed_reg), .x_out(hash_seed));
    bvsg_mix64 u_mix_idx  (.aclk(aclk), .en(en), .x_in(idx_key),  .x_out(hash_idx));

    always_ff @(posedge aclk) begin
        if (en) begin
            ks_reg <= hash_seed + 64'(step_reg) + hash_idx;
        end
    end

    bvsg_mix64 u_mix_key (.aclk(aclk), .en(en), .x_in(ks_reg), .x_out(key));
    bvsg_mix64 u_mix_b1  (.aclk(aclk), .en(en), .x_in(key), .x_out(b1));
    bvsg_mix64 u_mix_b2  (.aclk(aclk), .en(en), .x_in(key ^ KEY_XOR), .x_out(b2));

    // ---------------- angle ----------------
    logic signed [31:0] cos_raw, cos_al;

    // phase = m2 >> 22 is the top word of b2
    bvsg_cos u_cos (.aclk(aclk), .en(en), .phase(b2[63:32]), .cos_q30(cos_raw));

    bvsg_delay #(.WIDTH(32), .DEPTH(COS_DLY)) u_cos_dly (
        .aclk(aclk), .en(en), .d_in(cos_raw), .d_out(cos_al)
    );

    // ---------------- radius: -log2(u) ----------------
    logic [53:0] m1, lz_m_reg;
    logic [5:0]  lz_p, lz_p_reg;
    logic [53:0] norm_sh;

    assign m1 = {b1[63:11], 1'b1};

    always_comb begin
        lz_p = '0;
        for (int i = 0; i < 54; i++) begin
            if (m1[i]) lz_p = 6'(i);
        end
    end

    assign norm_sh = (lz_p_reg >= 6'd30) ? (lz_m_reg >> (lz_p_reg - 6'd30))
                                         : (lz_m_reg << (6'd30 - lz_p_reg));

    logic [30:0] sq_x_reg    [LOG_STEPS+1];
    logic [29:0] sq_frac_reg [LOG_STEPS+1];
    logic [5:0]  sq_p_reg    [LOG_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            lz_m_reg       <= m1;
            lz_p_reg       <= lz_p;
            sq_x_reg[0]    <= norm_sh[30:0];
            sq_frac_reg[0] <= '0;
            sq_p_reg[0]    <= lz_p_reg;
        end
    end

    for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_log
        logic [63:0] sq;
        assign sq = mul32(32'(sq_x_reg[k-1]), 32'(sq_x_reg[k-1]));
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_p_reg[k] <= sq_p_reg[k-1];
                // mantissa reached 2: halve and emit a one bit
                if (sq[61]) begin
                    sq_x_reg[k]    <= sq[61:31];
                    sq_frac_reg[k] <= {sq_frac_reg[k-1][28:0], 1'b1};
                end else begin
                    sq_x_reg[k]    <= sq[60:30];
                    sq_frac_reg[k] <= {sq_frac_reg[k-1][28:0], 1'b0};
                end
            end
        end
    end

    // ---------------- radius: scale and square root ----------------
    logic [35:0] nl;
    logic [58:0] t_prod;

    assign nl     = {6'd54 - sq_p_reg[LOG_STEPS], 30'd0} - 36'(sq_frac_reg[LOG_STEPS]);
    assign t_prod = 59'(nl) * 59'(TWO_LN2_Q22);

    logic [52:0] sr_v_reg   [SQRT_STEPS+1];
    logic [53:0] sr_res_reg [SQRT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_v_reg[0]   <= {t_prod[58:22], 16'd0};
            sr_res_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        localparam int BITPOS = 2*(SQRT_STEPS - j);
        logic [53:0] trial;
        assign trial = sr_res_reg[j-1] + (54'd1 << BITPOS);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (54'(sr_v_reg[j-1]) >= trial) begin
                    sr_v_reg[j]   <= sr_v_reg[j-1] - trial[52:0];
                    sr_res_reg[j] <= (sr_res_reg[j-1] >> 1) + (54'd1 << BITPOS);
                end else begin
                    sr_v_reg[j]   <= sr_v_reg[j-1];
                    sr_res_reg[j] <= sr_res_reg[j-1] >> 1;
                end
            end
        end
    end

    // ---------------- normal sample and update ----------------
    logic [26:0]        radius;
    logic [30:0]        cos_abs;
    logic [57:0]        mag_reg;
    logic               mneg_reg;
    logic [58:0]        mag_rnd;
    logic [20:0]        nq;
    logic signed [19:0] n_reg, n_p_reg, n_r_reg;

    assign radius  = sr_res_reg[SQRT_STEPS][26:0];
    assign cos_abs = cos_al[31] ? 31'(-cos_al) : cos_al[30:0];
    assign mag_rnd = 59'(mag_reg) + (59'd1 << 37);
    assign nq      = mag_rnd[58:38];

    logic [19:0]  n_abs;
    logic [32:0]  f_abs;
    logic [51:0]  np_reg;
    logic [64:0]  fp_reg;
    logic         nneg_reg, fneg_reg, frz_p_reg, frz_r_reg;
    logic signed [31:0] z_p_reg, z_r_reg;
    logic [29:0]  nterm_reg;
    logic [40:0]  fterm_reg;
    logic         nneg_r_reg, fneg_r_reg;
    logic [52:0]  np_rnd;
    logic [65:0]  fp_rnd;
    logic signed [43:0] zsum;
    logic signed [31:0] zsat;
    logic [31:0]  out_z_reg;
    logic [19:0]  out_n_reg;

    assign n_abs  = n_reg[19] ? 20'(-n_reg) : 20'(n_reg);
    assign f_abs  = side_out.fsum[32] ? 33'(-side_out.fsum) : 33'(side_out.fsum);
    assign np_rnd = 53'(np_reg) + (53'd1 << 22);
    assign fp_rnd = 66'(fp_reg) + (66'd1 << 23);

    always_comb begin
        zsum = 44'(z_r_reg)
             + (nneg_r_reg ? -44'(nterm_reg) : 44'(nterm_reg))
             + (fneg_r_reg ? -44'(fterm_reg) : 44'(fterm_reg));
        if (zsum > 44'sd2147483647) begin
            zsat = 32'sh7FFF_FFFF;
        end else if (zsum < -44'sd2147483648) begin
            zsat = 32'sh8000_0000;
        end else begin
            zsat = zsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // r * |cos|
            mag_reg  <= 58'(radius) * 58'(cos_abs);
            mneg_reg <= cos_al[31];
            // round half away from zero to Q5.15 and clamp
            if (mneg_reg) begin
                n_reg <= (nq > 21'd524288) ? 20'sh80000 : 20'(-nq);
            end else begin
                n_reg <= (nq > 21'd524287) ? 20'sd524287 : 20'(nq);
            end
            // scale products
            np_reg    <= 52'(n_abs) * 52'(nscale_reg);
            fp_reg    <= 65'(f_abs) * 65'(fscale_reg);
            nneg_reg  <= n_reg[19];
            fneg_reg  <= side_out.fsum[32];
            n_p_reg   <= n_reg;
            z_p_reg   <= side_out.z;
            frz_p_reg <= side_out.frozen;
            // round to Q16.16
            nterm_reg  <= np_rnd[52:23];
            fterm_reg  <= fp_rnd[64:24];
            nneg_r_reg <= nneg_reg;
            fneg_r_reg <= fneg_reg;
            n_r_reg    <= n_p_reg;
            z_r_reg    <= z_p_reg;
            frz_r_reg  <= frz_p_reg;
            // frozen vertex passes through, no noise reported
            out_z_reg  <= frz_r_reg ? z_r_reg : zsat;
            out_n_reg  <= frz_r_reg ? 20'd0 : n_r_reg;
        end
    end

    assign m_tdata = {4'd0, out_n_reg, out_z_reg};

endmodule

`default_nettype wire

FILE: src/bvsg_checker.sv
// Port-level checks for the Brownian vertex step block, bound to the top level.
`default_nettype none

module bvsg_port_checks
    import bvsg_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // held result beat keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input side advances exactly when the output register frees up
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // stalled pipe takes no input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // pad bits above the noise sample stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:52] == '0)
        else $error("nonzero pad bits in result beat");

endmodule

bind brownian_vertex_step_with_keyed_gaussian_unit bvsg_port_checks u_bvsg_port_checks (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

FILE: tb/bvsg_checker.sv
// Scoreboard for the Brownian vertex step block: predicts each result beat and compares.
`timescale 1ns / 1ps

module bvsg_checker
    import bvsg_pkg::*;
#(
    parameter int VIB = 16,
    parameter int SW  = ((VIB + 96 + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [SW-1:0]          s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [63:0]            cfg_wdata,
    output int                          n_errors,
    output int                          n_pending,
    output int                          n_results
);

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [19:0] noise;
    } height_t;

    logic [63:0] seed_r, step_r, fscale_r, nscale_r;
    height_t     height_q[$];

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] x;
        x = v + 64'h9E3779B97F4A7C15;
        x = (x ^ (x >> 30)) * 64'hBF58476D1CE4E5B9;
        x = (x ^ (x >> 27)) * 64'h94D049BB133111EB;
        return x ^ (x >> 31);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bit_r;
        res = 0;
        bit_r = 64'd1 << 62;
        while (bit_r > v) bit_r = bit_r >> 2;
        while (bit_r != 0) begin
            if (v >= res + bit_r) begin
                v = v - (res + bit_r);
                res = (res >> 1) + bit_r;
            end else begin
                res = res >> 1;
            end
            bit_r = bit_r >> 2;
        end
        return res;
    endfunction

    // sqrt(-2 ln(m/2^54)) in Q23
    function automatic logic [63:0] radius(input logic [63:0] m);
        int          p;
        logic [63:0] x, frac, nl, t;
        p = 53;
        frac = 0;
        while (p > 0 && m[p] == 1'b0) p--;
        x = (p >= 30) ? (m >> (p - 30)) : (m << (30 - p));
        for (int i = 0; i < 30; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                frac = frac | 1;
            end
        end
        nl = (64'd54 << 30) - (64'(p) << 30) - frac;
        t = (nl * 64'd5814540) >> 22;
        return int_sqrt(t << 16);
    endfunction

    function automatic logic signed [63:0] cosine(input logic [31:0] phase);
        logic [1:0]         q;
        logic [63:0]        f, g, y, p;
        logic signed [63:0] c;
        q = phase[31:30];
        f = 64'(phase[29:0]);
        g = q[0] ? ((64'd1 << 30) - f) : f;
        y = (g * g) >> 30;
        p = 64'd27060;
        p = 64'd987048 - ((p * y) >> 30);
        p = 64'd22401992 - ((p * y) >> 30);
        p = 64'd272375560 - ((p * y) >> 30);
        p = 64'd1324675879 - ((p * y) >> 30);
        c = $signed(64'd1 << 30) - $signed((p * y) >> 30);
        return (q == 2'd1 || q == 2'd2) ? -c : c;
    endfunction

    function automatic logic signed [63:0] round_away(input logic [63:0] mag,
                                                       input logic neg, input int sh);
        logic [63:0] q;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic height_t predict_height(input logic [SW-1:0] d, input logic [1:0] u);
        height_t            h;
        logic [63:0]        idx, key, b1, b2, m1, m2, r, mag;
        logic signed [63:0] c, n, fsum, fterm, nterm, z;
        logic               neg;
        idx = 64'(d[VIB-1:0]);
        z = 64'($signed(d[VIB+64 +: 32]));
        n = 0;
        if (!u[1]) begin
            key = splitmix(splitmix(seed_r) + step_r + splitmix(idx * 4 + 2));
            b1 = splitmix(key);
            b2 = splitmix(key ^ 64'hD1B54A32D192ED03);
            m1 = ((b1 >> 11) << 1) | 1;
            m2 = ((b2 >> 11) << 1) | 1;
            r = radius(m1);
            c = cosine(m2[53:22]);
            neg = c < 0;
            mag = r * (neg ? -c : c);
            n = round_away(mag, neg, 38);
            if (n > 524287) n = 524287;
            if (n < -524288) n = -524288;
            fsum = u[0] ? 64'sd0 : 64'($signed(d[VIB +: 32])) + 64'($signed(d[VIB+32 +: 32]));
            neg = fsum < 0;
            fterm = round_away((neg ? -fsum : fsum) * fscale_r, neg, 24);
            neg = n < 0;
            nterm = round_away((neg ? -n : n) * nscale_r, neg, 23);
            z = z + nterm + fterm;
            if (z > 64'sd2147483647) z = 64'sd2147483647;
            if (z < -64'sd2147483648) z = -64'sd2147483648;
        end
        h.z = z[31:0];
        h.noise = n[19:0];
        return h;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s at beat %0d: got %h want %h", what, n_results, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        height_t want;
        if (!aresetn) begin
            seed_r <= 0; step_r <= 0; fscale_r <= 0; nscale_r <= 0;
            n_errors = 0; n_results = 0;
            height_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (height_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(m_tdata), 0);
                end else begin
                    want = height_q.pop_front();
                    if (m_tdata[31:0] !== want.z)
                        report_mismatch("new_position_z", 64'(m_tdata[31:0]), 64'(want.z));
                    if (m_tdata[51:32] !== want.noise)
                        report_mismatch("noise_sample", 64'(m_tdata[51:32]), 64'(want.noise));
                    if (m_tdata[OUT_TDATA_W-1:52] !== '0)
                        report_mismatch("pad", 64'(m_tdata), 0);
                end
                n_results++;
            end
            if (s_tvalid && s_tready) height_q.push_back(predict_height(s_tdata, s_tuser));
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SEED:        seed_r <= cfg_wdata;
                    CFG_STEP_INDEX:  step_r <= 64'(cfg_wdata[31:0]);
                    CFG_FORCE_SCALE: fscale_r <= 64'(cfg_wdata[31:0]);
                    CFG_NOISE_SCALE: nscale_r <= 64'(cfg_wdata[31:0]);
                    default: ;
                endcase
            end
        end
        n_pending = height_q.size();
    end

endmodule

FILE: tb/brownian_vertex_step_with_keyed_gaussian_unit_tb.sv
// Testbench top: drives vertex beats and register phases, gives the verdict.
`timescale 1ns / 1ps

module brownian_vertex_step_with_keyed_gaussian_unit_tb
    import bvsg_pkg::*;
;

    localparam int VIB       = VERTEX_INDEX_BITS_DEF;
    localparam int SW        = ((VIB + 96 + 7) / 8) * 8;
    localparam int LATENCY   = 81;
    localparam int MAX_CYCLE = 400000;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic [SW-1:0]          s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   s_tvalid = 0;
    wire                    s_tready;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tvalid;
    logic                   m_tready = 0;
    logic                   cfg_we = 0;
    logic [1:0]             cfg_index = CFG_SEED;
    logic [63:0]            cfg_wdata = '0;
    int                     n_errors, n_pending, n_results;
    int                     cycle = 0;
    int                     n_sent = 0;
    int                     sink_gap = 0;
    bit                     sink_on = 0;

    always #2 aclk = ~aclk;

    brownian_vertex_step_with_keyed_gaussian_unit #(.VERTEX_INDEX_BITS(VIB)) DUT (
        .aclk, .aresetn, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
        .m_tdata, .m_tvalid, .m_tready, .cfg_we, .cfg_index, .cfg_wdata
    );

    bvsg_checker #(.VIB(VIB)) u_checker (
        .aclk, .aresetn, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
        .m_tdata, .m_tvalid, .m_tready, .cfg_we, .cfg_index, .cfg_wdata,
        .n_errors, .n_pending, .n_results
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // watchdog
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout at cycle %0d", cycle);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure: random-length gaps, with quiet stretches
    always @(negedge aclk) begin
        int g;
        if (!sink_on) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            g = ((n_sent / 100) % 3 == 0) ? 0 : gap_len();
            m_tready <= (g == 0);
            sink_gap <= (g > 0) ? g - 1 : 0;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // pass a beat; valid stays high across back-to-back beats
    task automatic send_vertex(input logic [VIB-1:0] idx, input logic [31:0] fc,
                               input logic [31:0] fa, input logic inv, input logic frz,
                               input logic [31:0] z, input bit paced);
        int g;
        g = paced ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {z, fa, fc, idx};
        s_tuser <= {frz, inv};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (n_pending != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_q16(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 65535) - 32768;
            3: return $urandom_range(0, 2097151) - 1048576;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [63:0] scales[6];
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        sink_on = 1;

        // directed: reset registers (all zero), then field extremes
        send_vertex('0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0);
        drain();
        write_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STEP_INDEX, 64'hFFFF_FFFF);
        write_reg(CFG_FORCE_SCALE, 64'hFFFF_FFFF);
        write_reg(CFG_NOISE_SCALE, 64'hFFFF_FFFF);
        // saturation both ways, invalid force, frozen, index extremes
        send_vertex({VIB{1'b1}}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0);
        send_vertex('0, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000, 0);
        send_vertex(16'h1234, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'h0, 0);
        send_vertex(16'h00FF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 0);
        send_vertex({VIB{1'b1}}, 32'hFFFF_FFFF, 32'h1, 1, 1, 32'h7FFF_FFFF, 0);
        for (int i = 0; i < 12; i++)
            send_vertex(i[VIB-1:0], 32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'h0, 0);
        drain();
        write_reg(CFG_FORCE_SCALE, 64'h0100_0000);
        write_reg(CFG_NOISE_SCALE, 64'h0000_0001);
        for (int i = 0; i < 6; i++)
            send_vertex(VIB'($urandom), $urandom, $urandom, 0, 0, $urandom, 0);
        drain();

        // random phases over several register settings
        scales = '{64'h0, 64'hFFFF_FFFF, 64'h0100_0000, 64'h0002_0000, 64'h0, 64'h0};
        for (int ph = 0; ph < 10; ph++) begin
            scales[4] = 64'($urandom);
            scales[5] = 64'($urandom_range(0, 32'h0400_0000));
            write_reg(CFG_SEED, (ph == 1) ? 64'h0 : {$urandom, $urandom});
            write_reg(CFG_STEP_INDEX, (ph == 2) ? 64'hFFFF_FFFF : 64'($urandom));
            write_reg(CFG_FORCE_SCALE, scales[$urandom_range(0, 5)]);
            write_reg(CFG_NOISE_SCALE, scales[$urandom_range(0, 5)]);
            for (int i = 0; i < 72; i++)
                send_vertex(VIB'($urandom), rand_q16($urandom_range(0, 6)),
                            rand_q16($urandom_range(0, 6)), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 7) == 0, rand_q16($urandom_range(0, 6)),
                            (ph % 3) != 0);
            drain();
        end

        $display("covered %0d vertex beats, %0d results, over 13 register settings",
                 n_sent, n_results);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
